@@ src/gaaf_pkg.sv @@
// ----------------------------------------------------------------------------
// gaaf_pkg
// Shared constants and types for the gyro/accelerometer attitude filter.
// ----------------------------------------------------------------------------
`default_nettype none

package gaaf_pkg;

    localparam int BIAS_FRACTION_BITS = 4;

    localparam int YAW_RATE_SHIFT    = 10;
    localparam int YAW_FILTER_SHIFT  = 3;
    localparam int ROLL_FILTER_SHIFT = 3;
    localparam int ROLL_GYRO_SHIFT   = 14;
    localparam int R_ANGLE           = 5;
    localparam int C1_R              = 7;

    localparam logic signed [31:0] C1_ROUND    = 32'sd64;
    localparam logic signed [31:0] C2_ROUND    = 32'sd16384;
    localparam logic signed [31:0] INTEG_ROUND = 32'sd256;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_YAW_GYRO_BIAS         = 3'd0,
        CFG_ROLL_ACCEL_OFFSET     = 3'd1,
        CFG_ROLL_GYRO_BIAS_START  = 3'd2,
        CFG_ACCEL_RATIO           = 3'd3,
        CFG_YAW_GAIN_SHIFT        = 3'd4,
        CFG_ROLL_ANGLE_GAIN_SHIFT = 3'd5,
        CFG_ROLL_RATE_GAIN_SHIFT  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [13:0] yaw_gyro_bias;
        logic [21:0] roll_accel_offset;
        logic [23:0] roll_gyro_bias_start;
        logic [11:0] accel_ratio;
        logic [4:0]  yaw_gain_shift;
        logic [3:0]  roll_angle_gain_shift;
        logic [3:0]  roll_rate_gain_shift;
    } cfg_t;

    localparam logic [11:0] ACCEL_RATIO_RESET           = 12'd2000;
    localparam logic [4:0]  YAW_GAIN_SHIFT_RESET        = 5'd10;
    localparam logic [3:0]  ROLL_ANGLE_GAIN_SHIFT_RESET = 4'd6;
    localparam logic [3:0]  ROLL_RATE_GAIN_SHIFT_RESET  = 4'd8;

endpackage

`default_nettype wire

@@ src/gyro_accel_attitude_filter.sv @@
// ----------------------------------------------------------------------------
// gyro_accel_attitude_filter
// Fixed-point complementary attitude filter. Each accepted sample transaction
// yields exactly one result transaction carrying the yaw command, the roll
// command and the updated roll angle. A sample is captured in the input
// register (the accelerometer scaling multiply is done on the way in). When
// the result register is empty or being taken, the filter state is updated
// and the result register loads at the same edge. One sample is accepted
// every cycle while sample stall is low; the rate is set by the single pass
// through the filter update between the input and result registers, whose
// state feeds back within that pass. Sample stall is raised only while the
// input register is full and the result register is full and stalled.
// Configuration writes take effect at the next edge.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_accel_attitude_filter
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_write_en,
    input  wire logic [gaaf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [gaaf_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                             sample_valid,
    output logic                                  sample_stall,
    input  wire logic [9:0]                       yaw_gyro,
    input  wire logic [9:0]                       roll_gyro,
    input  wire logic [9:0]                       roll_accel,
    input  wire logic signed [7:0]                roll_setpoint,
    input  wire logic signed [7:0]                yaw_setpoint,
    input  wire logic                             reload_bias,

    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output logic signed [31:0]                    yaw_command,
    output logic signed [31:0]                    roll_command,
    output logic signed [31:0]                    roll_angle_out
);

    gaaf_pkg::cfg_t cfg;

    logic               sample_accept;
    logic               result_load;
    logic [21:0]        accel_product;
    logic signed [31:0] accel_angle;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [9:0]         s1_yaw_gyro_reg;
    logic [9:0]         s1_roll_gyro_reg;
    logic signed [31:0] s1_accel_angle_reg;
    logic signed [7:0]  s1_roll_setpoint_reg;
    logic signed [7:0]  s1_yaw_setpoint_reg;
    logic               s1_reload_bias_reg;

    logic               result_valid_reg;
    logic               result_valid_next;
    logic signed [31:0] yaw_command_reg;
    logic signed [31:0] roll_command_reg;
    logic signed [31:0] roll_angle_out_reg;

    logic signed [31:0] yaw_command_calc;
    logic signed [31:0] roll_command_calc;
    logic signed [31:0] roll_angle_calc;

    gaaf_cfg_regs u_cfg_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    always_comb
    begin
        result_load   = s1_valid_reg && (!result_valid_reg || !result_stall);
        sample_stall  = s1_valid_reg && result_valid_reg && result_stall;
        sample_accept = sample_valid && !sample_stall;

        if (sample_accept)
            s1_valid_next = 1'b1;
        else if (result_load)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (result_load)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;

        accel_product = 22'(roll_accel) * 22'(cfg.accel_ratio);
        accel_angle   = signed'(32'(accel_product) - 32'(cfg.roll_accel_offset));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            s1_yaw_gyro_reg      <= yaw_gyro;
            s1_roll_gyro_reg     <= roll_gyro;
            s1_accel_angle_reg   <= accel_angle;
            s1_roll_setpoint_reg <= roll_setpoint;
            s1_yaw_setpoint_reg  <= yaw_setpoint;
            s1_reload_bias_reg   <= reload_bias;
        end
        if (result_load)
        begin
            yaw_command_reg    <= yaw_command_calc;
            roll_command_reg   <= roll_command_calc;
            roll_angle_out_reg <= roll_angle_calc;
        end
    end

    gaaf_yaw_path u_yaw_path
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .update_en      (result_load),
        .yaw_gyro_bias  (cfg.yaw_gyro_bias),
        .yaw_gain_shift (cfg.yaw_gain_shift),
        .yaw_gyro       (s1_yaw_gyro_reg),
        .yaw_setpoint   (s1_yaw_setpoint_reg),
        .yaw_command    (yaw_command_calc)
    );

    gaaf_roll_path u_roll_path
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .update_en             (result_load),
        .roll_gyro_bias_start  (cfg.roll_gyro_bias_start),
        .roll_angle_gain_shift (cfg.roll_angle_gain_shift),
        .roll_rate_gain_shift  (cfg.roll_rate_gain_shift),
        .roll_gyro             (s1_roll_gyro_reg),
        .accel_angle           (s1_accel_angle_reg),
        .roll_setpoint         (s1_roll_setpoint_reg),
        .reload_bias           (s1_reload_bias_reg),
        .roll_command          (roll_command_calc),
        .roll_angle            (roll_angle_calc)
    );

    assign result_valid   = result_valid_reg;
    assign yaw_command    = yaw_command_reg;
    assign roll_command   = roll_command_reg;
    assign roll_angle_out = roll_angle_out_reg;

    a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
        sample_accept |=> s1_valid_reg)
        else $error("accepted sample transaction not held in input register");

    a_s1_moves_to_result : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !(result_valid_reg && result_stall)) |=> result_valid_reg)
        else $error("input register advanced without a result transaction");

    a_blocked_s1_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && result_valid_reg && result_stall)
        |=> (s1_valid_reg && $stable(s1_accel_angle_reg) && $stable(s1_yaw_gyro_reg)
             && $stable(s1_roll_gyro_reg)))
        else $error("blocked input register lost its transaction");

endmodule

`default_nettype wire

@@ src/gaaf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// gaaf_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module gaaf_cfg_regs
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write_en,
    input  wire logic [gaaf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [gaaf_pkg::CFG_DATA_W-1:0]      cfg_data,
    output gaaf_pkg::cfg_t                            cfg
);

    gaaf_pkg::cfg_t cfg_reg;
    gaaf_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (gaaf_pkg::cfg_index_t'(cfg_index))
                gaaf_pkg::CFG_YAW_GYRO_BIAS:
                    cfg_next.yaw_gyro_bias = cfg_data[13:0];
                gaaf_pkg::CFG_ROLL_ACCEL_OFFSET:
                    cfg_next.roll_accel_offset = cfg_data[21:0];
                gaaf_pkg::CFG_ROLL_GYRO_BIAS_START:
                    cfg_next.roll_gyro_bias_start = cfg_data[23:0];
                gaaf_pkg::CFG_ACCEL_RATIO:
                    cfg_next.accel_ratio = cfg_data[11:0];
                gaaf_pkg::CFG_YAW_GAIN_SHIFT:
                    cfg_next.yaw_gain_shift = cfg_data[4:0];
                gaaf_pkg::CFG_ROLL_ANGLE_GAIN_SHIFT:
                    cfg_next.roll_angle_gain_shift = cfg_data[3:0];
                gaaf_pkg::CFG_ROLL_RATE_GAIN_SHIFT:
                    cfg_next.roll_rate_gain_shift = cfg_data[3:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.yaw_gyro_bias         <= '0;
            cfg_reg.roll_accel_offset     <= '0;
            cfg_reg.roll_gyro_bias_start  <= '0;
            cfg_reg.accel_ratio           <= gaaf_pkg::ACCEL_RATIO_RESET;
            cfg_reg.yaw_gain_shift        <= gaaf_pkg::YAW_GAIN_SHIFT_RESET;
            cfg_reg.roll_angle_gain_shift <= gaaf_pkg::ROLL_ANGLE_GAIN_SHIFT_RESET;
            cfg_reg.roll_rate_gain_shift  <= gaaf_pkg::ROLL_RATE_GAIN_SHIFT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/gaaf_yaw_path.sv @@
// ----------------------------------------------------------------------------
// gaaf_yaw_path
// Yaw rate bias removal, first-order low-pass and scaled yaw command.
// ----------------------------------------------------------------------------
`default_nettype none

module gaaf_yaw_path
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               update_en,
    input  wire logic [13:0]        yaw_gyro_bias,
    input  wire logic [4:0]         yaw_gain_shift,
    input  wire logic [9:0]         yaw_gyro,
    input  wire logic signed [7:0]  yaw_setpoint,
    output logic signed [31:0]      yaw_command
);

    logic signed [31:0] yaw_rate_filtered_reg;
    logic signed [31:0] yaw_rate_filtered_next;
    logic signed [31:0] dy;
    logic               gain_small;
    logic [3:0]         shr_amt;
    logic [4:0]         shl_amt;
    logic signed [31:0] scaled_rate;

    always_comb
    begin
        dy = (32'(yaw_gyro) << gaaf_pkg::YAW_RATE_SHIFT)
           - (32'(yaw_gyro_bias)
              << (gaaf_pkg::YAW_RATE_SHIFT - gaaf_pkg::BIAS_FRACTION_BITS));
        yaw_rate_filtered_next = yaw_rate_filtered_reg
                               - (yaw_rate_filtered_reg >>> gaaf_pkg::YAW_FILTER_SHIFT)
                               + (dy >>> gaaf_pkg::YAW_RATE_SHIFT);

        gain_small = (yaw_gain_shift <= 5'(gaaf_pkg::YAW_RATE_SHIFT));
        shr_amt    = 4'(5'(gaaf_pkg::YAW_RATE_SHIFT) - yaw_gain_shift);
        shl_amt    = 5'(yaw_gain_shift - 5'(gaaf_pkg::YAW_RATE_SHIFT));
        if (gain_small)
            scaled_rate = yaw_rate_filtered_next >>> shr_amt;
        else
            scaled_rate = yaw_rate_filtered_next << shl_amt;

        yaw_command = 32'(yaw_setpoint) + scaled_rate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            yaw_rate_filtered_reg <= '0;
        else if (update_en)
            yaw_rate_filtered_reg <= yaw_rate_filtered_next;
    end

endmodule

`default_nettype wire

@@ src/gaaf_roll_path.sv @@
// ----------------------------------------------------------------------------
// gaaf_roll_path
// Roll gyro/accelerometer fusion: rate filter, angle integration, angle
// correction, bias adaptation and roll command.
// ----------------------------------------------------------------------------
`default_nettype none

module gaaf_roll_path
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               update_en,
    input  wire logic [23:0]        roll_gyro_bias_start,
    input  wire logic [3:0]         roll_angle_gain_shift,
    input  wire logic [3:0]         roll_rate_gain_shift,
    input  wire logic [9:0]         roll_gyro,
    input  wire logic signed [31:0] accel_angle,
    input  wire logic signed [7:0]  roll_setpoint,
    input  wire logic               reload_bias,
    output logic signed [31:0]      roll_command,
    output logic signed [31:0]      roll_angle
);

    logic signed [31:0] roll_rate_filtered_reg;
    logic signed [31:0] roll_rate_filtered_next;
    logic signed [31:0] roll_angle_est_reg;
    logic signed [31:0] roll_angle_est_next;
    logic signed [31:0] roll_bias_est_reg;
    logic signed [31:0] roll_bias_est_next;
    logic signed [31:0] bias_eff;
    logic signed [31:0] dr;
    logic signed [31:0] angle_integ;
    logic signed [31:0] err;
    logic signed [31:0] neg_angle;
    logic [3:0]         p1;
    logic [3:0]         p2;
    logic [3:0]         shr_angle;
    logic [3:0]         shr_rate;

    always_comb
    begin
        if (reload_bias)
            bias_eff = signed'(32'(roll_gyro_bias_start));
        else
            bias_eff = roll_bias_est_reg;

        dr = (32'(roll_gyro) << gaaf_pkg::ROLL_GYRO_SHIFT) - bias_eff;
        roll_rate_filtered_next = roll_rate_filtered_reg
                                - (roll_rate_filtered_reg >>> gaaf_pkg::ROLL_FILTER_SHIFT)
                                + (dr >>> gaaf_pkg::ROLL_FILTER_SHIFT);

        angle_integ = roll_angle_est_reg
                    + ((roll_rate_filtered_next + gaaf_pkg::INTEG_ROUND)
                       >>> (gaaf_pkg::ROLL_GYRO_SHIFT - gaaf_pkg::R_ANGLE));
        roll_angle_est_next = angle_integ
                            - ((angle_integ - accel_angle + gaaf_pkg::C1_ROUND)
                               >>> gaaf_pkg::C1_R);
        err = roll_angle_est_next - accel_angle;
        roll_bias_est_next = bias_eff
                           + ((err + gaaf_pkg::C2_ROUND)
                              >>> gaaf_pkg::ROLL_GYRO_SHIFT);

        // clamp gain shifts so the right shift never goes negative
        if (roll_angle_gain_shift > 4'(gaaf_pkg::ROLL_GYRO_SHIFT))
            p1 = 4'(gaaf_pkg::ROLL_GYRO_SHIFT);
        else
            p1 = roll_angle_gain_shift;
        if (roll_rate_gain_shift > 4'(gaaf_pkg::ROLL_GYRO_SHIFT))
            p2 = 4'(gaaf_pkg::ROLL_GYRO_SHIFT);
        else
            p2 = roll_rate_gain_shift;
        shr_angle = 4'(gaaf_pkg::ROLL_GYRO_SHIFT) - p1;
        shr_rate  = 4'(gaaf_pkg::ROLL_GYRO_SHIFT) - p2;

        neg_angle    = 32'sd0 - roll_angle_est_next;
        roll_command = 32'(roll_setpoint) + (neg_angle >>> shr_angle)
                     - (roll_rate_filtered_next >>> shr_rate);
        roll_angle   = roll_angle_est_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_rate_filtered_reg <= '0;
            roll_angle_est_reg     <= '0;
            roll_bias_est_reg      <= '0;
        end
        else if (update_en)
        begin
            roll_rate_filtered_reg <= roll_rate_filtered_next;
            roll_angle_est_reg     <= roll_angle_est_next;
            roll_bias_est_reg      <= roll_bias_est_next;
        end
    end

endmodule

`default_nettype wire

@@ dv/tb_gyro_accel_attitude_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gyro_accel_attitude_filter
// Self-checking bench for the attitude filter. A queue of sensor samples
// feeds a burst driver, and a predictor of the yaw and roll paths computes
// the commands for every accepted transaction. A monitor compares each result
// with the oldest prediction while the result side stalls on its own pattern.
// Register settings change between phases once the pipeline has drained:
// reset values, all zero, all ones, then random settings with random streams.
// ----------------------------------------------------------------------------
module tb_gyro_accel_attitude_filter;

    localparam logic [gaaf_pkg::CFG_INDEX_W-1:0] CFG_INDEX_UNUSED = 3'd7;

    typedef struct {
        logic [9:0]        yaw_gyro;
        logic [9:0]        roll_gyro;
        logic [9:0]        roll_accel;
        logic signed [7:0] roll_setpoint;
        logic signed [7:0] yaw_setpoint;
        logic              reload_bias;
    } sensor_sample_t;

    typedef struct {
        logic signed [31:0] yaw_command;
        logic signed [31:0] roll_command;
        logic signed [31:0] roll_angle;
    } attitude_command_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BURSTS
    } stall_mode_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_write_en = 1'b0;
    logic [gaaf_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [gaaf_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
    logic                              sample_valid = 1'b0;
    logic                              sample_stall;
    logic [9:0]                        yaw_gyro = '0;
    logic [9:0]                        roll_gyro = '0;
    logic [9:0]                        roll_accel = '0;
    logic signed [7:0]                 roll_setpoint = '0;
    logic signed [7:0]                 yaw_setpoint = '0;
    logic                              reload_bias = 1'b0;
    logic                              result_valid;
    logic                              result_stall = 1'b0;
    logic signed [31:0]                yaw_command;
    logic signed [31:0]                roll_command;
    logic signed [31:0]                roll_angle_out;

    sensor_sample_t    sensor_samples[$];
    attitude_command_t expected_commands[$];
    attitude_command_t oldest_command;
    int                mismatch_count = 0;

    gaaf_pkg::cfg_t     filter_cfg;
    logic signed [31:0] yaw_rate_q;
    logic signed [31:0] roll_rate_q;
    logic signed [31:0] roll_angle_q;
    logic signed [31:0] roll_bias_q;

    int          taken_count = 0;
    int          served_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          stall_run = 0;

    gyro_accel_attitude_filter dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .yaw_gyro       (yaw_gyro),
        .roll_gyro      (roll_gyro),
        .roll_accel     (roll_accel),
        .roll_setpoint  (roll_setpoint),
        .yaw_setpoint   (yaw_setpoint),
        .reload_bias    (reload_bias),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .yaw_command    (yaw_command),
        .roll_command   (roll_command),
        .roll_angle_out (roll_angle_out)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: %s", $realtime, msg);
    endtask

    task automatic advance_attitude_model(input sensor_sample_t s);
        logic signed [31:0] dy;
        logic signed [31:0] dr;
        logic signed [31:0] acc;
        logic signed [31:0] err;
        logic [3:0]         p1;
        logic [3:0]         p2;
        attitude_command_t  cmd;
        if (s.reload_bias)
        begin
            roll_bias_q = 32'(filter_cfg.roll_gyro_bias_start);
        end
        dy = (32'(s.yaw_gyro) << gaaf_pkg::YAW_RATE_SHIFT)
           - (32'(filter_cfg.yaw_gyro_bias)
              << (gaaf_pkg::YAW_RATE_SHIFT - gaaf_pkg::BIAS_FRACTION_BITS));
        yaw_rate_q = yaw_rate_q - (yaw_rate_q >>> gaaf_pkg::YAW_FILTER_SHIFT)
                   + (dy >>> gaaf_pkg::YAW_RATE_SHIFT);
        if (filter_cfg.yaw_gain_shift <= gaaf_pkg::YAW_RATE_SHIFT)
        begin
            cmd.yaw_command = s.yaw_setpoint
                            + (yaw_rate_q >>> (gaaf_pkg::YAW_RATE_SHIFT
                                               - filter_cfg.yaw_gain_shift));
        end
        else
        begin
            cmd.yaw_command = s.yaw_setpoint
                            + (yaw_rate_q << (filter_cfg.yaw_gain_shift
                                              - gaaf_pkg::YAW_RATE_SHIFT));
        end

        dr = (32'(s.roll_gyro) << gaaf_pkg::ROLL_GYRO_SHIFT) - roll_bias_q;
        roll_rate_q = roll_rate_q - (roll_rate_q >>> gaaf_pkg::ROLL_FILTER_SHIFT)
                    + (dr >>> gaaf_pkg::ROLL_FILTER_SHIFT);
        roll_angle_q = roll_angle_q
                     + ((roll_rate_q + gaaf_pkg::INTEG_ROUND)
                        >>> (gaaf_pkg::ROLL_GYRO_SHIFT - gaaf_pkg::R_ANGLE));
        acc = 32'(s.roll_accel) * 32'(filter_cfg.accel_ratio)
            - 32'(filter_cfg.roll_accel_offset);
        roll_angle_q = roll_angle_q
                     - ((roll_angle_q - acc + gaaf_pkg::C1_ROUND) >>> gaaf_pkg::C1_R);
        err = roll_angle_q - acc;
        roll_bias_q = roll_bias_q
                    + ((err + gaaf_pkg::C2_ROUND) >>> gaaf_pkg::ROLL_GYRO_SHIFT);

        p1 = (filter_cfg.roll_angle_gain_shift > gaaf_pkg::ROLL_GYRO_SHIFT)
           ? 4'(gaaf_pkg::ROLL_GYRO_SHIFT) : filter_cfg.roll_angle_gain_shift;
        p2 = (filter_cfg.roll_rate_gain_shift > gaaf_pkg::ROLL_GYRO_SHIFT)
           ? 4'(gaaf_pkg::ROLL_GYRO_SHIFT) : filter_cfg.roll_rate_gain_shift;
        cmd.roll_command = s.roll_setpoint
                         + ((-roll_angle_q) >>> (gaaf_pkg::ROLL_GYRO_SHIFT - p1))
                         - (roll_rate_q >>> (gaaf_pkg::ROLL_GYRO_SHIFT - p2));
        cmd.roll_angle = roll_angle_q;
        expected_commands.push_back(cmd);
    endtask

    task automatic write_register(input logic [gaaf_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [gaaf_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        case (idx)
            gaaf_pkg::CFG_YAW_GYRO_BIAS:
                filter_cfg.yaw_gyro_bias = data[13:0];
            gaaf_pkg::CFG_ROLL_ACCEL_OFFSET:
                filter_cfg.roll_accel_offset = data[21:0];
            gaaf_pkg::CFG_ROLL_GYRO_BIAS_START:
                filter_cfg.roll_gyro_bias_start = data[23:0];
            gaaf_pkg::CFG_ACCEL_RATIO:
                filter_cfg.accel_ratio = data[11:0];
            gaaf_pkg::CFG_YAW_GAIN_SHIFT:
                filter_cfg.yaw_gain_shift = data[4:0];
            gaaf_pkg::CFG_ROLL_ANGLE_GAIN_SHIFT:
                filter_cfg.roll_angle_gain_shift = data[3:0];
            gaaf_pkg::CFG_ROLL_RATE_GAIN_SHIFT:
                filter_cfg.roll_rate_gain_shift = data[3:0];
            default: ;
        endcase
    endtask

    task automatic program_filter(input logic [gaaf_pkg::CFG_DATA_W-1:0] yaw_bias,
                                  input logic [gaaf_pkg::CFG_DATA_W-1:0] accel_offset,
                                  input logic [gaaf_pkg::CFG_DATA_W-1:0] bias_start,
                                  input logic [gaaf_pkg::CFG_DATA_W-1:0] ratio,
                                  input logic [gaaf_pkg::CFG_DATA_W-1:0] yaw_gain,
                                  input logic [gaaf_pkg::CFG_DATA_W-1:0] angle_gain,
                                  input logic [gaaf_pkg::CFG_DATA_W-1:0] rate_gain,
                                  input bit stray_write);
        write_register(gaaf_pkg::CFG_YAW_GYRO_BIAS, yaw_bias);
        write_register(gaaf_pkg::CFG_ROLL_ACCEL_OFFSET, accel_offset);
        write_register(gaaf_pkg::CFG_ROLL_GYRO_BIAS_START, bias_start);
        write_register(gaaf_pkg::CFG_ACCEL_RATIO, ratio);
        write_register(gaaf_pkg::CFG_YAW_GAIN_SHIFT, yaw_gain);
        write_register(gaaf_pkg::CFG_ROLL_ANGLE_GAIN_SHIFT, angle_gain);
        write_register(gaaf_pkg::CFG_ROLL_RATE_GAIN_SHIFT, rate_gain);
        if (stray_write)
        begin
            write_register(CFG_INDEX_UNUSED, gaaf_pkg::CFG_DATA_W'($urandom()));
        end
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic push_sample(input logic [9:0] yg, input logic [9:0] rg,
                               input logic [9:0] ra, input logic signed [7:0] rs,
                               input logic signed [7:0] ys, input logic rl);
        sensor_sample_t s;
        s.yaw_gyro      = yg;
        s.roll_gyro     = rg;
        s.roll_accel    = ra;
        s.roll_setpoint = rs;
        s.yaw_setpoint  = ys;
        s.reload_bias   = rl;
        sensor_samples.push_back(s);
    endtask

    function automatic logic [9:0] near_value(input int center);
        int v;
        v = center + int'($urandom_range(0, 32)) - 16;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 1023)
        begin
            v = 1023;
        end
        return 10'(v);
    endfunction

    task automatic queue_sensor_stream(input int count);
        int style;
        int cy;
        int cr;
        int ca;
        style = $urandom_range(0, 2);
        cy = $urandom_range(0, 1023);
        cr = $urandom_range(0, 1023);
        ca = $urandom_range(0, 1023);
        for (int i = 0; i < count; i++)
        begin
            if (style == 0)
            begin
                push_sample(10'($urandom()), 10'($urandom()), 10'($urandom()),
                            8'($urandom()), 8'($urandom()), $urandom_range(0, 39) == 0);
            end
            else
            begin
                if (style == 2)
                begin
                    cy = (cy + int'($urandom_range(0, 4)) - 2) & 1023;
                    cr = (cr + int'($urandom_range(0, 4)) - 2) & 1023;
                    ca = (ca + int'($urandom_range(0, 4)) - 2) & 1023;
                end
                push_sample(near_value(cy), near_value(cr), near_value(ca),
                            8'($urandom()), 8'($urandom()), $urandom_range(0, 59) == 0);
            end
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (sensor_samples.size() != 0 || expected_commands.size() != 0 || sample_valid);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && sample_valid && !sample_stall)
        begin
            advance_attitude_model(sensor_samples.pop_front());
            taken_count++;
        end
    end

    always @(negedge clk)
    begin
        if (!sample_valid || served_count != taken_count)
        begin
            served_count = taken_count;
            if (gap_left != 0)
            begin
                gap_left--;
                sample_valid <= 1'b0;
            end
            else if (rst_n && sensor_samples.size() != 0)
            begin
                yaw_gyro      <= sensor_samples[0].yaw_gyro;
                roll_gyro     <= sensor_samples[0].roll_gyro;
                roll_accel    <= sensor_samples[0].roll_accel;
                roll_setpoint <= sensor_samples[0].roll_setpoint;
                yaw_setpoint  <= sensor_samples[0].yaw_setpoint;
                reload_bias   <= sensor_samples[0].reload_bias;
                sample_valid  <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    burst_left = $urandom_range(40, 160);
                    gap_left   = 0;
                end
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = $urandom_range(0, 5);
                end
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(40, 250);
        end
        else
        begin
            mode_left--;
        end
        case (stall_mode)
            STALL_NONE:  result_stall <= 1'b0;
            STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: result_stall <= ($urandom_range(0, 9) < 7);
            default:
            begin
                if (stall_run == 0)
                begin
                    stall_run = $urandom_range(1, 10);
                    result_stall <= !result_stall;
                end
                else
                begin
                    stall_run--;
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_commands.size() == 0)
            begin
                report_mismatch("result transaction with no sample outstanding");
            end
            else
            begin
                oldest_command = expected_commands.pop_front();
                if (yaw_command !== oldest_command.yaw_command)
                begin
                    report_mismatch($sformatf("yaw_command: got %0d, expected %0d",
                                              yaw_command, oldest_command.yaw_command));
                end
                if (roll_command !== oldest_command.roll_command)
                begin
                    report_mismatch($sformatf("roll_command: got %0d, expected %0d",
                                              roll_command, oldest_command.roll_command));
                end
                if (roll_angle_out !== oldest_command.roll_angle)
                begin
                    report_mismatch($sformatf("roll_angle_out: got %0d, expected %0d",
                                              roll_angle_out, oldest_command.roll_angle));
                end
            end
        end
    end

    initial
    begin
        filter_cfg.yaw_gyro_bias         = '0;
        filter_cfg.roll_accel_offset     = '0;
        filter_cfg.roll_gyro_bias_start  = '0;
        filter_cfg.accel_ratio           = gaaf_pkg::ACCEL_RATIO_RESET;
        filter_cfg.yaw_gain_shift        = gaaf_pkg::YAW_GAIN_SHIFT_RESET;
        filter_cfg.roll_angle_gain_shift = gaaf_pkg::ROLL_ANGLE_GAIN_SHIFT_RESET;
        filter_cfg.roll_rate_gain_shift  = gaaf_pkg::ROLL_RATE_GAIN_SHIFT_RESET;
        yaw_rate_q   = '0;
        roll_rate_q  = '0;
        roll_angle_q = '0;
        roll_bias_q  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_sample(10'd0, 10'd0, 10'd0, 8'sd0, 8'sd0, 1'b0);
        push_sample(10'd1023, 10'd1023, 10'd1023, 8'sd127, 8'sd127, 1'b0);
        push_sample(10'd1023, 10'd1023, 10'd1023, 8'sd127, 8'sd127, 1'b0);
        push_sample(10'd0, 10'd0, 10'd0, -8'sd128, -8'sd128, 1'b0);
        push_sample(10'd0, 10'd1023, 10'd0, 8'sd127, -8'sd128, 1'b1);
        push_sample(10'd1023, 10'd0, 10'd1023, -8'sd128, 8'sd127, 1'b0);
        push_sample(10'd512, 10'd512, 10'd512, -8'sd1, 8'sd1, 1'b0);
        push_sample(10'd341, 10'd682, 10'd341, 8'sd85, -8'sd86, 1'b1);
        push_sample(10'd682, 10'd341, 10'd682, -8'sd86, 8'sd85, 1'b0);
        push_sample(10'd1, 10'd1, 10'd1, 8'sd1, -8'sd1, 1'b0);
        push_sample(10'd1022, 10'd1022, 10'd1022, 8'sd126, -8'sd127, 1'b0);
        push_sample(10'd0, 10'd0, 10'd1023, 8'sd0, 8'sd0, 1'b0);
        wait_drained();

        program_filter(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0);
        push_sample(10'd1023, 10'd1023, 10'd1023, 8'sd127, 8'sd127, 1'b1);
        push_sample(10'd0, 10'd0, 10'd0, -8'sd128, -8'sd128, 1'b0);
        push_sample(10'd1023, 10'd0, 10'd1023, 8'sd127, -8'sd128, 1'b0);
        push_sample(10'd0, 10'd1023, 10'd0, -8'sd128, 8'sd127, 1'b0);
        push_sample(10'd512, 10'd512, 10'd512, 8'sd0, 8'sd0, 1'b1);
        wait_drained();

        program_filter(24'd16383, 24'd4194303, 24'd16777215, 24'd4095,
                       24'd31, 24'd15, 24'd15, 1'b1);
        push_sample(10'd0, 10'd0, 10'd0, 8'sd0, 8'sd0, 1'b1);
        push_sample(10'd1023, 10'd1023, 10'd1023, 8'sd127, 8'sd127, 1'b0);
        push_sample(10'd1023, 10'd1023, 10'd1023, 8'sd127, 8'sd127, 1'b0);
        push_sample(10'd0, 10'd0, 10'd0, -8'sd128, -8'sd128, 1'b0);
        push_sample(10'd1023, 10'd0, 10'd0, -8'sd128, 8'sd127, 1'b1);
        push_sample(10'd0, 10'd1023, 10'd1023, 8'sd127, -8'sd128, 1'b0);
        push_sample(10'd512, 10'd512, 10'd512, 8'sd0, 8'sd0, 1'b0);
        push_sample(10'd1023, 10'd1023, 10'd0, 8'sd0, 8'sd0, 1'b0);
        wait_drained();

        for (int phase = 0; phase < 12; phase++)
        begin
            program_filter(gaaf_pkg::CFG_DATA_W'($urandom()),
                           gaaf_pkg::CFG_DATA_W'($urandom()),
                           gaaf_pkg::CFG_DATA_W'($urandom()),
                           gaaf_pkg::CFG_DATA_W'($urandom()),
                           {19'($urandom()), ($urandom_range(0, 5) == 0)
                                ? 5'($urandom()) : 5'($urandom_range(0, 20))},
                           gaaf_pkg::CFG_DATA_W'($urandom()),
                           gaaf_pkg::CFG_DATA_W'($urandom()),
                           $urandom_range(0, 3) == 0);
            queue_sensor_stream($urandom_range(110, 170));
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
